// ===== rtl/core/tcl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the GB2312 text cell layout block.
package tcl_pkg;

    // Grid size
    localparam int ROWS = 10;
    localparam int COLS = 20;

    localparam int ROW_W = 4;
    localparam int COL_W = 5;

    // Wrap indent saturates so that a wide glyph always fits after a wrap.
    localparam logic [COL_W-1:0] INDENT_MAX = COL_W'(COLS - 3);

    // Request codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // Result codes
    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Control bytes
    localparam logic [7:0] CHR_NUL = 8'h00;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_CR  = 8'h0D;

    // GB2312 lead byte ranges and glyph code bases
    localparam logic [7:0]  GB_LEAD_LO1  = 8'hA1;
    localparam logic [7:0]  GB_LEAD_HI1  = 8'hA9;
    localparam logic [7:0]  GB_LEAD_LO2  = 8'hB0;
    localparam logic [7:0]  GB_LEAD_HI2  = 8'hF7;
    localparam logic [7:0]  GB_GAP       = 8'h06;
    localparam logic [7:0]  GB_CODE_BASE = 8'hA1;
    localparam logic [15:0] GB_ZONE_SPAN = 16'd94;
    localparam logic [15:0] GB_GLYPH_BASE    = 16'h4000;
    localparam logic [15:0] ASCII_GLYPH_BASE = 16'h2000;

    // Most results one request can cause
    localparam int RES_DEPTH = 3;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic             action;
        logic [ROW_W-1:0] start_row;
        logic [COL_W-1:0] start_col;
        logic [COL_W-1:0] indent;
        logic [7:0]       char_byte;
    } tcl_char_t;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [15:0]      glyph;
        logic [7:0]       line_count;
        logic             last;
    } tcl_cell_t;

endpackage

// ===== rtl/core/tcl_char_if.sv =====
`timescale 1ns / 1ps
// Request channel carrying start items and string bytes.
interface tcl_char_if import tcl_pkg::*; ();
    logic      valid;
    logic      ready;
    tcl_char_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tcl_cell_if.sv =====
`timescale 1ns / 1ps
// Result channel carrying cell writes and done reports.
interface tcl_cell_if import tcl_pkg::*; ();
    logic      valid;
    logic      ready;
    tcl_cell_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/text_cell_layout_gb2312.sv =====
`timescale 1ns / 1ps
// Top level of the GB2312 text cell layout block.
//
//   Channel | Direction | Carries
//   --------+-----------+---------------------------------------------
//   chars   | sink      | start items and string bytes, one per request
//   cells   | source    | cell writes and done reports, one per handshake
//
// A request is taken into an input register, processed once the result buffer is free, and its
// results (zero to three) are loaded into a result buffer.
// The result port drains one result per cycle while cells is ready; the next request can wait
// in the input register while the buffer drains.
// The next request is processed in the cycle the buffer gives up its last result.
// Reset clears the position, the held lead byte and the buffer; the block is idle.
// A stall on cells holds the buffer and, once the input register is full, chars.
module text_cell_layout_gb2312 import tcl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tcl_char_if.sink    chars,
    tcl_cell_if.source  cells
);

    localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(COLS);

    // Input register
    logic            chr_vld_reg, chr_vld_next;
    tcl_char_t       chr_reg, chr_next;

    // Layout state
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [COL_W-1:0] indent_reg, indent_next;
    logic [7:0]       lines_reg, lines_next;
    logic             pend_reg, pend_next;
    logic [7:0]       lead_reg, lead_next;
    logic             active_reg, active_next;

    // Result buffer, drained from entry 0
    tcl_cell_t            res_reg [RES_DEPTH];
    tcl_cell_t            res_next [RES_DEPTH];
    tcl_cell_t            res_new [RES_DEPTH];
    logic [RES_CNT_W-1:0] rem_reg, rem_next;
    logic [RES_CNT_W-1:0] res_n;

    logic out_fire, in_fire, buf_free, proc_fire;

    logic [ROW_W:0]   row_inc;
    logic [COL_W:0]   col_inc, col_inc2;
    logic [COL_W-1:0] ind_sat;
    logic [7:0]       b;
    logic [7:0]       lead_adj, zone;
    logic [15:0]      gsum, glyph_hi, glyph_lo, glyph_asc;
    logic             is_lead;

    function automatic tcl_cell_t make_res(logic kind, logic [ROW_W-1:0] row,
                                           logic [COL_W-1:0] col, logic [15:0] glyph,
                                           logic [7:0] lines);
        tcl_cell_t r;
        r.kind       = kind;
        r.cell_row   = row;
        r.cell_col   = col;
        r.glyph      = glyph;
        r.line_count = lines;
        r.last       = 1'b0;
        return r;
    endfunction

    assign out_fire  = cells.valid && cells.ready;
    assign in_fire   = chars.valid && chars.ready;
    assign buf_free  = (rem_reg == '0) || ((rem_reg == RES_CNT_W'(1)) && out_fire);
    assign proc_fire = chr_vld_reg && buf_free;

    assign chars.ready = !chr_vld_reg || proc_fire;
    assign cells.valid = (rem_reg != '0);
    assign cells.data  = res_reg[0];

    // Datapath terms for the request in the input register
    assign b         = chr_reg.char_byte;
    assign row_inc   = {1'b0, cur_row_reg} + (ROW_W + 1)'(1);
    assign col_inc   = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
    assign col_inc2  = {1'b0, cur_col_reg} + (COL_W + 1)'(2);
    assign ind_sat   = (chr_reg.indent > INDENT_MAX) ? INDENT_MAX : chr_reg.indent;
    assign lead_adj  = (lead_reg >= GB_LEAD_LO2) ? (lead_reg - GB_GAP) : lead_reg;
    assign zone      = lead_adj - GB_CODE_BASE;
    assign gsum      = ({8'h00, zone} * GB_ZONE_SPAN) + ({8'h00, b} - {8'h00, GB_CODE_BASE});
    assign glyph_hi  = {gsum[14:0], 1'b0} + GB_GLYPH_BASE;
    assign glyph_lo  = {glyph_hi[15:1], 1'b1};
    assign glyph_asc = ASCII_GLYPH_BASE + {8'h00, b};
    assign is_lead   = ((b >= GB_LEAD_LO1) && (b <= GB_LEAD_HI1))
                    || ((b >= GB_LEAD_LO2) && (b <= GB_LEAD_HI2));

    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        indent_next  = indent_reg;
        lines_next   = lines_reg;
        pend_next    = pend_reg;
        lead_next    = lead_reg;
        active_next  = active_reg;
        res_n        = '0;
        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_new[i] = '0;
        end

        if (proc_fire)
        begin
            if (chr_reg.action == ACT_START)
            begin
                pend_next   = 1'b0;
                lead_next   = '0;
                indent_next = ind_sat;
                lines_next  = 8'd1;
                if ({1'b0, chr_reg.start_row} >= ROW_LIMIT)
                begin
                    cur_row_next = chr_reg.start_row;
                    cur_col_next = chr_reg.start_col;
                    active_next  = 1'b0;
                    res_new[0]   = make_res(KIND_DONE, chr_reg.start_row,
                                            chr_reg.start_col, 16'h0000, 8'd0);
                    res_n        = RES_CNT_W'(1);
                end
                else if ({1'b0, chr_reg.start_col} >= COL_LIMIT)
                begin
                    // Start column past the edge moves to the indent on the next row.
                    cur_row_next = chr_reg.start_row + ROW_W'(1);
                    cur_col_next = ind_sat;
                    if (({1'b0, chr_reg.start_row} + (ROW_W + 1)'(1)) >= ROW_LIMIT)
                    begin
                        active_next = 1'b0;
                        res_new[0]  = make_res(KIND_DONE, chr_reg.start_row + ROW_W'(1),
                                               ind_sat, 16'h0000, 8'd1);
                        res_n       = RES_CNT_W'(1);
                    end
                    else
                    begin
                        active_next = 1'b1;
                    end
                end
                else
                begin
                    cur_row_next = chr_reg.start_row;
                    cur_col_next = chr_reg.start_col;
                    active_next  = 1'b1;
                end
            end
            else if (active_reg)
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (col_inc >= COL_LIMIT)
                    begin
                        // Wide glyph at the last column: blank it and wrap first.
                        res_new[0]   = make_res(KIND_CELL, cur_row_reg, cur_col_reg,
                                                16'h0000, 8'd0);
                        cur_row_next = row_inc[ROW_W-1:0];
                        if (row_inc >= ROW_LIMIT)
                        begin
                            cur_col_next = indent_reg;
                            active_next  = 1'b0;
                            res_new[1]   = make_res(KIND_DONE, row_inc[ROW_W-1:0],
                                                    indent_reg, 16'h0000, lines_reg);
                            res_n        = RES_CNT_W'(2);
                        end
                        else
                        begin
                            cur_col_next = indent_reg + COL_W'(2);
                            res_new[1]   = make_res(KIND_CELL, row_inc[ROW_W-1:0],
                                                    indent_reg, glyph_hi, 8'd0);
                            res_new[2]   = make_res(KIND_CELL, row_inc[ROW_W-1:0],
                                                    indent_reg + COL_W'(1), glyph_lo, 8'd0);
                            res_n        = RES_CNT_W'(3);
                        end
                    end
                    else
                    begin
                        res_new[0] = make_res(KIND_CELL, cur_row_reg, cur_col_reg,
                                              glyph_hi, 8'd0);
                        res_new[1] = make_res(KIND_CELL, cur_row_reg, col_inc[COL_W-1:0],
                                              glyph_lo, 8'd0);
                        res_n      = RES_CNT_W'(2);
                        if (col_inc2 >= COL_LIMIT)
                        begin
                            cur_col_next = indent_reg;
                            cur_row_next = row_inc[ROW_W-1:0];
                            if (row_inc >= ROW_LIMIT)
                            begin
                                active_next = 1'b0;
                                res_new[2]  = make_res(KIND_DONE, row_inc[ROW_W-1:0],
                                                       indent_reg, 16'h0000, lines_reg);
                                res_n       = RES_CNT_W'(3);
                            end
                        end
                        else
                        begin
                            cur_col_next = col_inc2[COL_W-1:0];
                        end
                    end
                end
                else if (b == CHR_NUL)
                begin
                    active_next = 1'b0;
                    res_new[0]  = make_res(KIND_DONE, cur_row_reg, cur_col_reg,
                                           16'h0000, lines_reg);
                    res_n       = RES_CNT_W'(1);
                end
                else if (b == CHR_LF)
                begin
                    cur_row_next = row_inc[ROW_W-1:0];
                    if (row_inc >= ROW_LIMIT)
                    begin
                        active_next = 1'b0;
                        res_new[0]  = make_res(KIND_DONE, row_inc[ROW_W-1:0], cur_col_reg,
                                               16'h0000, lines_reg);
                        res_n       = RES_CNT_W'(1);
                    end
                    else if (lines_reg != 8'hFF)
                    begin
                        lines_next = lines_reg + 8'd1;
                    end
                end
                else if (b == CHR_CR)
                begin
                    cur_col_next = '0;
                end
                else if (is_lead)
                begin
                    lead_next = b;
                    pend_next = 1'b1;
                end
                else
                begin
                    res_new[0] = make_res(KIND_CELL, cur_row_reg, cur_col_reg,
                                          glyph_asc, 8'd0);
                    res_n      = RES_CNT_W'(1);
                    if (col_inc >= COL_LIMIT)
                    begin
                        cur_col_next = indent_reg;
                        cur_row_next = row_inc[ROW_W-1:0];
                        if (row_inc >= ROW_LIMIT)
                        begin
                            active_next = 1'b0;
                            res_new[1]  = make_res(KIND_DONE, row_inc[ROW_W-1:0],
                                                   indent_reg, 16'h0000, lines_reg);
                            res_n       = RES_CNT_W'(2);
                        end
                    end
                    else
                    begin
                        cur_col_next = col_inc[COL_W-1:0];
                    end
                end
            end
        end

        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_new[i].last = ((RES_CNT_W'(i) + RES_CNT_W'(1)) == res_n);
        end
    end

    // Input register and result buffer next values
    always_comb
    begin
        chr_vld_next = chr_vld_reg;
        chr_next     = chr_reg;
        if (in_fire)
        begin
            chr_vld_next = 1'b1;
            chr_next     = chars.data;
        end
        else if (proc_fire)
        begin
            chr_vld_next = 1'b0;
        end

        rem_next = rem_reg;
        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (proc_fire)
        begin
            rem_next = res_n;
            for (int i = 0; i < RES_DEPTH; i++)
            begin
                res_next[i] = res_new[i];
            end
        end
        else if (out_fire)
        begin
            rem_next = rem_reg - RES_CNT_W'(1);
            for (int i = 0; i < RES_DEPTH - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_vld_reg <= 1'b0;
            rem_reg     <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            indent_reg  <= '0;
            lines_reg   <= 8'd1;
            pend_reg    <= 1'b0;
            lead_reg    <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            chr_vld_reg <= chr_vld_next;
            rem_reg     <= rem_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            indent_reg  <= indent_next;
            lines_reg   <= lines_next;
            pend_reg    <= pend_next;
            lead_reg    <= lead_next;
            active_reg  <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg <= chr_next;
        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    // The buffer never holds more results than one request can cause.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result buffer count out of range");

    // A done report is always the final result of its request.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && (cells.data.kind == KIND_DONE)) |-> cells.data.last)
        else $error("done report not marked last");

    // After the last result leaves with nothing new loaded, the port goes quiet.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && cells.data.last && !proc_fire) |=> !cells.valid)
        else $error("result left over after last");

    // While a string is active the position stays on the grid.
    a_pos_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (({1'b0, cur_col_reg} < COL_LIMIT)
                        && ({1'b0, cur_row_reg} < ROW_LIMIT)))
        else $error("active position off the grid");

    // A held lead byte only exists while a string is active.
    a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> active_reg)
        else $error("lead byte held while idle");

endmodule
